[rtl/vsbc_pkg.sv]
package vsbc_pkg;

    // Field widths
    localparam int KIND_W    = 2;
    localparam int CYC_W     = 16;
    localparam int LID_W     = 3;
    localparam int SEL_W     = 2;
    localparam int TVAL_W    = 24;
    localparam int IRQ_W     = 11;
    localparam int LINE_W    = 10;
    localparam int LCOUNT_W  = 11;
    localparam int CNT_W     = 32;
    localparam int RTMR_W    = 25;
    localparam int LTMR_W    = 18;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Timers
    localparam int RTMR_COUNT = 4;
    localparam int LIST_COUNT = 5;
    localparam logic [LTMR_W-1:0] LIST_DELAY = LTMR_W'(200);

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LIST_END  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ARM_TIMER = 2'd2;

    // Render timer selects
    localparam logic [SEL_W-1:0] TMR_COMBINED = 2'd0;
    localparam logic [SEL_W-1:0] TMR_ISP      = 2'd1;
    localparam logic [SEL_W-1:0] TMR_TSP      = 2'd2;
    localparam logic [SEL_W-1:0] TMR_VIDEO    = 2'd3;

    // Interrupt bit positions
    localparam int IRQ_SCAN1  = 0;
    localparam int IRQ_SCAN2  = 1;
    localparam int IRQ_VBLANK = 2;
    localparam int IRQ_DONE   = 3;
    localparam int IRQ_ISP    = 4;
    localparam int IRQ_VIDEO  = 5;
    localparam int IRQ_LIST   = 6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CYC_PER_LINE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_IRQ_ONE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_IRQ_TWO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VBLANK_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VBLANK_END   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERLACE    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_MODE   = 3'd7;

    // Line counter restarts one before line 0
    localparam logic [LINE_W-1:0]   LINE_RESET   = '1;
    localparam logic [LCOUNT_W-1:0] LCOUNT_RESET = 11'd512;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CYC_W-1:0]  cycles;
        logic [LID_W-1:0]  list_id;
        logic [SEL_W-1:0]  timer_select;
        logic [TVAL_W-1:0] timer_value;
    } in_item_t;

    typedef struct packed {
        logic [IRQ_W-1:0]  irq_bits;
        logic              render_finished;
        logic [LINE_W-1:0] scanline_now;
        logic              in_vblank;
        logic              field_bit;
    } out_item_t;

    typedef struct packed {
        logic [CYC_W-1:0]    cyc_per_line;
        logic [LCOUNT_W-1:0] line_count;
        logic [LINE_W-1:0]   scan_irq_one_line;
        logic [LINE_W-1:0]   scan_irq_two_line;
        logic [LINE_W-1:0]   vblank_start_line;
        logic [LINE_W-1:0]   vblank_end_line;
        logic                interlace_on;
        logic                delay_mode;
    } cfg_t;

    // Beam unit result: scan/vblank irqs and status after the item
    typedef struct packed {
        logic [2:0]        irq_scan;
        logic [LINE_W-1:0] scanline;
        logic              vblank;
        logic              field;
    } line_res_t;

    // Timer unit result
    typedef struct packed {
        logic [IRQ_W-1:0] irq;
        logic             fin;
    } tmr_res_t;

endpackage

[rtl/vsbc_line.sv]
module vsbc_line (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fire,
    input  logic                      tick,
    input  logic [vsbc_pkg::CYC_W-1:0] cycles,
    input  vsbc_pkg::cfg_t            cfg,
    output vsbc_pkg::line_res_t       res
);
    import vsbc_pkg::*;

    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [LINE_W-1:0]   line_reg, line_adv;
    logic                vblank_reg, vblank_adv;
    logic                field_reg, field_adv;
    logic [CNT_W:0]      diff;
    logic [CNT_W-1:0]    sat;
    logic [CNT_W-1:0]    lc_ext;
    logic                below;
    logic                adv;
    logic [LCOUNT_W-1:0] step;

    always_comb
    begin
        lc_ext = {{(CNT_W-CYC_W){1'b0}}, cfg.cyc_per_line};
        diff   = {cnt_reg[CNT_W-1], cnt_reg} - {{(CNT_W-CYC_W+1){1'b0}}, cycles};
        // clamp at the most negative 32-bit value
        sat    = (diff[CNT_W] & ~diff[CNT_W-1]) ? {1'b1, {(CNT_W-1){1'b0}}}
                                                : diff[CNT_W-1:0];
        below  = $signed(sat) < $signed(lc_ext);
        cnt_next = below ? (sat + lc_ext) : sat;
        adv    = tick & below;

        step     = {1'b0, line_reg} + LCOUNT_W'(1);
        line_adv = (step >= cfg.line_count || step[LCOUNT_W-1]) ? '0 : step[LINE_W-1:0];

        vblank_adv = vblank_reg;
        if (cfg.vblank_start_line == line_adv)
        begin
            vblank_adv = 1'b1;
        end
        if (cfg.vblank_end_line == line_adv)
        begin
            vblank_adv = 1'b0;
        end
        field_adv = cfg.interlace_on & ~field_reg;

        res.irq_scan = '0;
        if (adv)
        begin
            res.irq_scan[IRQ_SCAN1]  = (cfg.scan_irq_one_line == line_adv);
            res.irq_scan[IRQ_SCAN2]  = (cfg.scan_irq_two_line == line_adv);
            res.irq_scan[IRQ_VBLANK] = (cfg.vblank_start_line == line_adv);
        end
        res.scanline = adv ? line_adv   : line_reg;
        res.vblank   = adv ? vblank_adv : vblank_reg;
        res.field    = adv ? field_adv  : field_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            line_reg   <= LINE_RESET;
            vblank_reg <= 1'b0;
            field_reg  <= 1'b0;
        end
        else if (fire && tick)
        begin
            cnt_reg <= cnt_next;
            if (adv)
            begin
                line_reg   <= line_adv;
                vblank_reg <= vblank_adv;
                field_reg  <= field_adv;
            end
        end
    end

endmodule

[rtl/vsbc_timers.sv]
module vsbc_timers (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  vsbc_pkg::in_item_t  item,
    input  logic                delay_mode,
    output vsbc_pkg::tmr_res_t  res
);
    import vsbc_pkg::*;

    logic [RTMR_W-1:0]     rt_reg   [RTMR_COUNT];
    logic [RTMR_W-1:0]     rt_next  [RTMR_COUNT];
    logic [RTMR_W-1:0]     rt_dec   [RTMR_COUNT];
    logic [RTMR_COUNT-1:0] rt_exp;
    logic [LTMR_W-1:0]     lt_reg   [LIST_COUNT];
    logic [LTMR_W-1:0]     lt_next  [LIST_COUNT];
    logic [LTMR_W-1:0]     lt_dec   [LIST_COUNT];
    logic [LIST_COUNT-1:0] pend_reg, pend_next;
    logic                  tick, list_end, arm;

    always_comb
    begin
        tick     = (item.kind == KIND_TICK);
        list_end = (item.kind == KIND_LIST_END);
        arm      = (item.kind == KIND_ARM_TIMER);
        res      = '0;

        for (int r = 0; r < RTMR_COUNT; r++)
        begin
            rt_dec[r]  = rt_reg[r] - {{(RTMR_W-CYC_W){1'b0}}, item.cycles};
            rt_next[r] = rt_reg[r];
            rt_exp[r]  = 1'b0;
            // only a running (positive) timer counts down
            if (tick && $signed(rt_reg[r]) > 0)
            begin
                rt_next[r] = rt_dec[r];
                rt_exp[r]  = $signed(rt_dec[r]) <= 0;
            end
            if (arm && item.timer_select == SEL_W'(r))
            begin
                rt_next[r] = {{(RTMR_W-TVAL_W){1'b0}}, item.timer_value};
            end
        end

        if (rt_exp[TMR_COMBINED])
        begin
            res.irq[IRQ_DONE]  = 1'b1;
            res.irq[IRQ_ISP]   = 1'b1;
            res.irq[IRQ_VIDEO] = 1'b1;
            res.fin            = 1'b1;
        end
        if (rt_exp[TMR_ISP])
        begin
            res.irq[IRQ_ISP] = 1'b1;
        end
        if (rt_exp[TMR_TSP])
        begin
            res.irq[IRQ_DONE] = 1'b1;
        end
        if (rt_exp[TMR_VIDEO])
        begin
            res.irq[IRQ_VIDEO] = 1'b1;
            res.fin            = 1'b1;
        end

        pend_next = pend_reg;
        for (int i = 0; i < LIST_COUNT; i++)
        begin
            lt_dec[i]  = lt_reg[i] - {{(LTMR_W-CYC_W){1'b0}}, item.cycles};
            lt_next[i] = lt_reg[i];
            if (tick && pend_reg[i])
            begin
                lt_next[i] = lt_dec[i];
                if ($signed(lt_dec[i]) <= 0)
                begin
                    pend_next[i] = 1'b0;
                    if (IRQ_LIST + i < IRQ_W)
                    begin
                        res.irq[IRQ_LIST + i] = 1'b1;
                    end
                end
            end
            if (list_end && item.list_id == LID_W'(i))
            begin
                if (!delay_mode)
                begin
                    if (IRQ_LIST + i < IRQ_W)
                    begin
                        res.irq[IRQ_LIST + i] = 1'b1;
                    end
                end
                else
                begin
                    lt_next[i]   = LIST_DELAY;
                    pend_next[i] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < RTMR_COUNT; r++)
            begin
                rt_reg[r] <= '0;
            end
            for (int i = 0; i < LIST_COUNT; i++)
            begin
                lt_reg[i] <= '0;
            end
            pend_reg <= '0;
        end
        else if (fire)
        begin
            for (int r = 0; r < RTMR_COUNT; r++)
            begin
                rt_reg[r] <= rt_next[r];
            end
            for (int i = 0; i < LIST_COUNT; i++)
            begin
                lt_reg[i] <= lt_next[i];
            end
            pend_reg <= pend_next;
        end
    end

endmodule

[rtl/video_sync_beam_counter_irq_top.sv]
// Channel  | Dir | Handshake                 | Payload
// ---------+-----+---------------------------+--------------------------------
// item     | in  | item_valid / item_ready   | vsbc_pkg::in_item_t
// result   | out | result_valid/result_ready | vsbc_pkg::out_item_t
// cfg      | in  | cfg_valid / cfg_ready     | cfg_index (3b), cfg_data (16b)
//
// One item per clock sustained while result_ready stays high. An item enters
// the input register, is worked through the beam and timer units in a single
// pass and lands in the result register once that is free or drains.
// Reset (rst_n, async, low) clears all counters, timers and valid flags; the
// scanline restarts one before line 0 and registers take their defaults.
// A stalled result holds the input register; once that is full the item
// channel stalls too. cfg_ready is always high.
module video_sync_beam_counter_irq_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  vsbc_pkg::in_item_t               item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output vsbc_pkg::out_item_t              result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vsbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vsbc_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import vsbc_pkg::*;

    cfg_t      cfg_reg;
    in_item_t  item_reg;
    logic      item_valid_reg;
    out_item_t res_reg, res_next;
    logic      res_valid_reg;
    logic      advance;
    logic      is_tick;
    line_res_t line_res;
    tmr_res_t  tmr_res;

    // Input register moves on whenever the result register is free or drains
    assign advance    = item_valid_reg & (~res_valid_reg | result_ready);
    assign item_ready = ~item_valid_reg | advance;
    assign is_tick    = (item_reg.kind == KIND_TICK);
    assign cfg_ready  = 1'b1;

    vsbc_line u_line (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .tick   (is_tick),
        .cycles (item_reg.cycles),
        .cfg    (cfg_reg),
        .res    (line_res)
    );

    vsbc_timers u_timers (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .item       (item_reg),
        .delay_mode (cfg_reg.delay_mode),
        .res        (tmr_res)
    );

    always_comb
    begin
        res_next.irq_bits        = tmr_res.irq | {{(IRQ_W-3){1'b0}}, line_res.irq_scan};
        res_next.render_finished = tmr_res.fin;
        res_next.scanline_now    = line_res.scanline;
        res_next.in_vblank       = line_res.vblank;
        res_next.field_bit       = line_res.field;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cyc_per_line      <= '0;
            cfg_reg.line_count        <= LCOUNT_RESET;
            cfg_reg.scan_irq_one_line <= '0;
            cfg_reg.scan_irq_two_line <= '0;
            cfg_reg.vblank_start_line <= '0;
            cfg_reg.vblank_end_line   <= '0;
            cfg_reg.interlace_on      <= 1'b0;
            cfg_reg.delay_mode        <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CYC_PER_LINE: cfg_reg.cyc_per_line      <= cfg_data;
                CFG_LINE_COUNT:   cfg_reg.line_count        <= cfg_data[LCOUNT_W-1:0];
                CFG_SCAN_IRQ_ONE: cfg_reg.scan_irq_one_line <= cfg_data[LINE_W-1:0];
                CFG_SCAN_IRQ_TWO: cfg_reg.scan_irq_two_line <= cfg_data[LINE_W-1:0];
                CFG_VBLANK_START: cfg_reg.vblank_start_line <= cfg_data[LINE_W-1:0];
                CFG_VBLANK_END:   cfg_reg.vblank_end_line   <= cfg_data[LINE_W-1:0];
                CFG_INTERLACE:    cfg_reg.interlace_on      <= cfg_data[0];
                CFG_DELAY_MODE:   cfg_reg.delay_mode        <= cfg_data[0];
                default:          ;
            endcase
        end
    end

endmodule

[rtl/vsbc_checker.sv]
module vsbc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           item_valid,
    input logic                           item_ready,
    input logic                           result_valid,
    input logic                           result_ready,
    input vsbc_pkg::out_item_t            result
);
    import vsbc_pkg::*;

    // stalled result holds its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // a fresh result follows a transfer in, by way of the input and result registers
    a_res_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready, 2))
        else $error("result without a matching transfer in");

    // input register full behind a stalled result: no further transfer in
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready && $past(result_valid && !result_ready)
        && $past(item_valid && item_ready) |-> !item_ready)
        else $error("item taken while pipeline full");

    // render finished only with a done or video interrupt
    a_fin_irq: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.render_finished |->
        result.irq_bits[IRQ_DONE] || result.irq_bits[IRQ_VIDEO])
        else $error("render finished without its interrupt");

endmodule

bind video_sync_beam_counter_irq_top vsbc_checker u_vsbc_checker (.*);
